/* hw/rtl/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, register codes and stage payload types for the
// ray/sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int GUARD_W    = 14;
    localparam int RAD_W      = WORD_W - 1;
    localparam int IN_DATA_W  = 6 * WORD_W;
    localparam int OUT_DATA_W = 128;
    localparam int REG_IDX_W  = 2;

    // digit-by-digit square root: 92-bit radicand, 46-bit root
    localparam int SQ_IN_W  = 92;
    localparam int SQ_RT_W  = SQ_IN_W / 2;
    localparam int SQ_REM_W = SQ_RT_W + 1;

    // restoring divider: 81-bit dividend, 46-bit divisor, 36-bit quotient
    localparam int DIV_NUM_W = 81;
    localparam int DIV_DEN_W = SQ_RT_W;
    localparam int DIV_Q_W   = 36;

    localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Z = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS   = 2'd3;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 31'h0001_0000;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_RT_W-1:0]  root;
        logic [SQ_IN_W-1:0]  x;
    } sq_t;

    typedef struct packed {
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_DEN_W-1:0] rem;
        logic [DIV_Q_W-1:0]   nq;
    } dv_t;

    typedef struct packed {
        logic                   func;
        logic                   zero;
        logic                   hneg;
        logic [2:0]             dsgn;
        logic [2:0][WORD_W-1:0] org;
        logic [2:0][WORD_W-1:0] dmag;
        logic [65:0]            l2;
        logic [64:0]            pm;
    } pre_t;

    typedef struct packed {
        logic                   func;
        logic                   zero;
        logic                   hneg;
        logic [2:0]             dsgn;
        logic [2:0][WORD_W-1:0] org;
        logic [2:0][WORD_W-1:0] dmag;
        logic [65:0]            l2;
    } hdiv_t;

    typedef struct packed {
        logic                   func;
        logic                   miss;
        logic                   hneg;
        logic [33:0]            hm;
        logic [2:0]             dsgn;
        logic [2:0][WORD_W-1:0] org;
        logic [2:0][WORD_W-1:0] dmag;
        logic [DIV_DEN_W-1:0]   nd;
    } root_t;

    typedef struct packed {
        logic                   miss;
        logic [34:0]            t;
        logic [2:0]             dsgn;
        logic [2:0][WORD_W-1:0] org;
        logic [2:0][WORD_W-1:0] dmag;
        logic [DIV_DEN_W-1:0]   nd;
    } pnt_t;

endpackage

/* hw/rtl/rsi_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rsi_sqrt_cell
// One root bit of a pipelined integer square root.
// ----------------------------------------------------------------------------
module rsi_sqrt_cell (
    input  logic          clk,
    input  logic          en,
    input  rsi_pkg::sq_t  cell_in,
    output rsi_pkg::sq_t  cell_out
);
    import rsi_pkg::*;

    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] test;
    logic [SQ_REM_W+1:0] diff;
    logic                ge;
    sq_t                 out_reg;

    always_comb
    begin
        trial = {cell_in.rem, cell_in.x[SQ_IN_W-1 -: 2]};
        test  = {1'b0, cell_in.root, 2'b01};
        diff  = trial - test;
        ge    = (trial >= test);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.rem  <= ge ? diff[SQ_REM_W-1:0] : trial[SQ_REM_W-1:0];
            out_reg.root <= {cell_in.root[SQ_RT_W-2:0], ge};
            out_reg.x    <= {cell_in.x[SQ_IN_W-3:0], 2'b00};
        end
    end

    assign cell_out = out_reg;

endmodule

/* hw/rtl/rsi_div_cell.sv */
// ----------------------------------------------------------------------------
// rsi_div_cell
// One quotient bit of a pipelined restoring divider.
// ----------------------------------------------------------------------------
module rsi_div_cell (
    input  logic          clk,
    input  logic          en,
    input  rsi_pkg::dv_t  cell_in,
    output rsi_pkg::dv_t  cell_out
);
    import rsi_pkg::*;

    logic [DIV_DEN_W:0] trial;
    logic [DIV_DEN_W:0] diff;
    logic               ge;
    dv_t                out_reg;

    always_comb
    begin
        trial = {cell_in.rem, cell_in.nq[DIV_Q_W-1]};
        diff  = trial - {1'b0, cell_in.den};
        ge    = (trial >= {1'b0, cell_in.den});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.den <= cell_in.den;
            out_reg.rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            out_reg.nq  <= {cell_in.nq[DIV_Q_W-2:0], ge};
        end
    end

    assign cell_out = out_reg;

endmodule

/* hw/rtl/ray_sphere_intersect_unit.sv */
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit
// Ray/sphere intersection, one ray per clock, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one ray item per clock and returns one result item per ray, in order.
// The pipeline is built around four bit-serial chains:
// two 46-cell square roots (direction length, discriminant) and two 36-cell
// dividers (the projection h, then three lanes for the hit point offsets).
// The whole pipeline advances together; it holds while a result waits at the
// output and the sink is not ready. Sphere registers are written with cfg_we
// and must only change while no ray is in flight.
module ray_sphere_intersect_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rsi_pkg::REG_IDX_W-1:0]     cfg_addr,
    input  logic [rsi_pkg::WORD_W-1:0]        cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [rsi_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // distance, point_x, point_y, point_z, zero fill
    output logic [rsi_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // hit
    output logic                              m_axis_tuser
);
    import rsi_pkg::*;

    localparam int SQ_STAGES  = SQ_RT_W;
    localparam int DIV_STAGES = DIV_Q_W;

    logic en;

    // configuration
    logic [2:0][WORD_W-1:0] ctr_reg;
    logic [RAD_W-1:0]       rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
            rad_reg <= RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CENTER_X: ctr_reg[0] <= cfg_wdata;
                REG_CENTER_Y: ctr_reg[1] <= cfg_wdata;
                REG_CENTER_Z: ctr_reg[2] <= cfg_wdata;
                REG_RADIUS:   rad_reg    <= cfg_wdata[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    // front stages
    logic                   v0_reg, v1_reg, v2_reg, v3_reg;
    logic                   s0_func_reg;
    logic [2:0][WORD_W-1:0] s0_org_reg, s0_dmag_reg;
    logic [2:0][WORD_W:0]   s0_lmag_reg;
    logic [2:0]             s0_dsgn_reg, s0_lsgn_reg;

    logic                   s1_func_reg;
    logic [2:0][WORD_W-1:0] s1_org_reg, s1_dmag_reg;
    logic [2:0]             s1_dsgn_reg, s1_xs_reg;
    logic [2:0][63:0]       s1_dd_reg;
    logic [2:0][65:0]       s1_ll_reg;
    logic [2:0][64:0]       s1_dl_reg;

    logic                   s2_func_reg;
    logic [2:0][WORD_W-1:0] s2_org_reg, s2_dmag_reg;
    logic [2:0]             s2_dsgn_reg;
    logic [63:0]            s2_q_reg;
    logic [65:0]            s2_l2_reg;
    logic [64:0]            s2_pos_reg, s2_neg_reg;

    pre_t                   s3_reg;
    logic [63:0]            s3_q_reg;

    logic [2:0][WORD_W-1:0] in_org, in_dir;
    logic [2:0][WORD_W:0]   in_l;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_org[i] = s_axis_tdata[i*WORD_W +: WORD_W];
            in_dir[i] = s_axis_tdata[(i+3)*WORD_W +: WORD_W];
            in_l[i]   = {in_org[i][WORD_W-1], in_org[i]} - {ctr_reg[i][WORD_W-1], ctr_reg[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_func_reg <= s_axis_tuser;
            for (int i = 0; i < 3; i++)
            begin
                s0_org_reg[i]  <= in_org[i];
                s0_dsgn_reg[i] <= in_dir[i][WORD_W-1];
                s0_dmag_reg[i] <= in_dir[i][WORD_W-1] ? (~in_dir[i] + 1'b1) : in_dir[i];
                s0_lsgn_reg[i] <= in_l[i][WORD_W];
                s0_lmag_reg[i] <= in_l[i][WORD_W] ? (~in_l[i] + 1'b1) : in_l[i];
            end

            s1_func_reg <= s0_func_reg;
            s1_org_reg  <= s0_org_reg;
            s1_dmag_reg <= s0_dmag_reg;
            s1_dsgn_reg <= s0_dsgn_reg;
            for (int i = 0; i < 3; i++)
            begin
                s1_dd_reg[i] <= s0_dmag_reg[i] * s0_dmag_reg[i];
                s1_ll_reg[i] <= s0_lmag_reg[i] * s0_lmag_reg[i];
                s1_dl_reg[i] <= s0_dmag_reg[i] * s0_lmag_reg[i];
                s1_xs_reg[i] <= s0_dsgn_reg[i] ^ s0_lsgn_reg[i];
            end

            s2_func_reg <= s1_func_reg;
            s2_org_reg  <= s1_org_reg;
            s2_dmag_reg <= s1_dmag_reg;
            s2_dsgn_reg <= s1_dsgn_reg;
            s2_q_reg    <= s1_dd_reg[0] + s1_dd_reg[1] + s1_dd_reg[2];
            s2_l2_reg   <= s1_ll_reg[0] + s1_ll_reg[1] + s1_ll_reg[2];
            s2_pos_reg  <= (s1_xs_reg[0] ? 65'd0 : s1_dl_reg[0])
                         + (s1_xs_reg[1] ? 65'd0 : s1_dl_reg[1])
                         + (s1_xs_reg[2] ? 65'd0 : s1_dl_reg[2]);
            s2_neg_reg  <= (s1_xs_reg[0] ? s1_dl_reg[0] : 65'd0)
                         + (s1_xs_reg[1] ? s1_dl_reg[1] : 65'd0)
                         + (s1_xs_reg[2] ? s1_dl_reg[2] : 65'd0);

            s3_reg.func <= s2_func_reg;
            s3_reg.zero <= (s2_q_reg == 64'd0);
            s3_reg.hneg <= (s2_pos_reg < s2_neg_reg);
            s3_reg.dsgn <= s2_dsgn_reg;
            s3_reg.org  <= s2_org_reg;
            s3_reg.dmag <= s2_dmag_reg;
            s3_reg.l2   <= s2_l2_reg;
            s3_reg.pm   <= (s2_pos_reg < s2_neg_reg) ? (s2_neg_reg - s2_pos_reg)
                                                     : (s2_pos_reg - s2_neg_reg);
            s3_q_reg    <= s2_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_axis_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // direction length: nd = isqrt(q * 2^(2*GUARD))
    sq_t  sq1 [0:SQ_STAGES];
    pre_t p1  [0:SQ_STAGES];
    logic v1c [0:SQ_STAGES];

    assign sq1[0] = '{rem: '0, root: '0, x: {s3_q_reg, {(2*GUARD_W){1'b0}}}};
    assign p1[0]  = s3_reg;
    assign v1c[0] = v3_reg;

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_sq1
        logic vk_reg;
        pre_t pk_reg;

        rsi_sqrt_cell u_cell (
            .clk      (clk),
            .en       (en),
            .cell_in  (sq1[k]),
            .cell_out (sq1[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vk_reg <= 1'b0;
            else if (en)
                vk_reg <= v1c[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                pk_reg <= p1[k];
        end

        assign v1c[k+1] = vk_reg;
        assign p1[k+1]  = pk_reg;
    end

    // h = (D.L) * 2^GUARD / nd, rounded
    logic [DIV_DEN_W-1:0] nd;
    logic [DIV_NUM_W-1:0] numh;
    dv_t                  s4_dv_reg;
    hdiv_t                s4_reg;
    logic                 v4_reg;

    assign nd   = sq1[SQ_STAGES].root;
    assign numh = {2'b00, p1[SQ_STAGES].pm, {GUARD_W{1'b0}}}
                + {{(DIV_NUM_W-DIV_DEN_W+1){1'b0}}, nd[DIV_DEN_W-1:1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_dv_reg.den <= nd;
            s4_dv_reg.rem <= {{(DIV_DEN_W-(DIV_NUM_W-DIV_Q_W)){1'b0}},
                              numh[DIV_NUM_W-1:DIV_Q_W]};
            s4_dv_reg.nq  <= numh[DIV_Q_W-1:0];
            s4_reg.func   <= p1[SQ_STAGES].func;
            s4_reg.zero   <= p1[SQ_STAGES].zero;
            s4_reg.hneg   <= p1[SQ_STAGES].hneg;
            s4_reg.dsgn   <= p1[SQ_STAGES].dsgn;
            s4_reg.org    <= p1[SQ_STAGES].org;
            s4_reg.dmag   <= p1[SQ_STAGES].dmag;
            s4_reg.l2     <= p1[SQ_STAGES].l2;
        end
    end

    dv_t   dq1 [0:DIV_STAGES];
    hdiv_t p2  [0:DIV_STAGES];
    logic  v2c [0:DIV_STAGES];

    assign dq1[0] = s4_dv_reg;
    assign p2[0]  = s4_reg;
    assign v2c[0] = v4_reg;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_dv1
        logic  vk_reg;
        hdiv_t pk_reg;

        rsi_div_cell u_cell (
            .clk      (clk),
            .en       (en),
            .cell_in  (dq1[k]),
            .cell_out (dq1[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vk_reg <= 1'b0;
            else if (en)
                vk_reg <= v2c[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                pk_reg <= p2[k];
        end

        assign v2c[k+1] = vk_reg;
        assign p2[k+1]  = pk_reg;
    end

    // discriminant = h^2 + r^2 - |L|^2
    root_t       s5_reg;
    logic [65:0] s5_l2_reg;
    logic [67:0] s5_hsq_reg;
    logic [61:0] s5_rsq_reg;
    logic        v5_reg;

    root_t       s6_reg;
    sq_t         s6_sq_reg;
    logic        v6_reg;
    logic [68:0] hr;
    logic [68:0] disc;

    assign hr   = {1'b0, s5_hsq_reg} + {7'd0, s5_rsq_reg};
    assign disc = hr - {3'd0, s5_l2_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_reg.func <= p2[DIV_STAGES].func;
            s5_reg.miss <= p2[DIV_STAGES].zero;
            s5_reg.hneg <= p2[DIV_STAGES].hneg;
            s5_reg.hm   <= dq1[DIV_STAGES].nq[33:0];
            s5_reg.dsgn <= p2[DIV_STAGES].dsgn;
            s5_reg.org  <= p2[DIV_STAGES].org;
            s5_reg.dmag <= p2[DIV_STAGES].dmag;
            s5_reg.nd   <= dq1[DIV_STAGES].den;
            s5_l2_reg   <= p2[DIV_STAGES].l2;
            s5_hsq_reg  <= dq1[DIV_STAGES].nq[33:0] * dq1[DIV_STAGES].nq[33:0];
            s5_rsq_reg  <= rad_reg * rad_reg;

            s6_reg.func <= s5_reg.func;
            s6_reg.miss <= s5_reg.miss | ({3'd0, s5_l2_reg} > hr);
            s6_reg.hneg <= s5_reg.hneg;
            s6_reg.hm   <= s5_reg.hm;
            s6_reg.dsgn <= s5_reg.dsgn;
            s6_reg.org  <= s5_reg.org;
            s6_reg.dmag <= s5_reg.dmag;
            s6_reg.nd   <= s5_reg.nd;
            s6_sq_reg   <= '{rem: '0, root: '0,
                             x: {{(SQ_IN_W-67){1'b0}}, disc[66:0]}};
        end
    end

    sq_t   sq2 [0:SQ_STAGES];
    root_t p3  [0:SQ_STAGES];
    logic  v3c [0:SQ_STAGES];

    assign sq2[0] = s6_sq_reg;
    assign p3[0]  = s6_reg;
    assign v3c[0] = v6_reg;

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_sq2
        logic  vk_reg;
        root_t pk_reg;

        rsi_sqrt_cell u_cell (
            .clk      (clk),
            .en       (en),
            .cell_in  (sq2[k]),
            .cell_out (sq2[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vk_reg <= 1'b0;
            else if (en)
                vk_reg <= v3c[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                pk_reg <= p3[k];
        end

        assign v3c[k+1] = vk_reg;
        assign p3[k+1]  = pk_reg;
    end

    // root selection
    root_t       rt;
    logic [36:0] mh, t1, t2, tsel;
    pnt_t        s7_reg;
    logic        v7_reg;

    always_comb
    begin
        rt   = p3[SQ_STAGES];
        mh   = rt.hneg ? {3'd0, rt.hm} : (37'd0 - {3'd0, rt.hm});
        t1   = mh - {3'd0, sq2[SQ_STAGES].root[33:0]};
        t2   = mh + {3'd0, sq2[SQ_STAGES].root[33:0]};
        tsel = (rt.func || t1[36]) ? t2 : t1;
    end

    // offsets: |D_i| * t * 2^GUARD / nd
    pnt_t                   s8_reg, s9_reg;
    logic                   v8_reg, v9_reg;
    logic [2:0][66:0]       s8_prod_reg;
    dv_t  [2:0]             s9_dv_reg;
    logic [2:0][DIV_NUM_W-1:0] numo;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            numo[i] = {1'b0, s8_prod_reg[i][65:0], {GUARD_W{1'b0}}}
                    + {{(DIV_NUM_W-DIV_DEN_W+1){1'b0}}, s8_reg.nd[DIV_DEN_W-1:1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_reg.miss <= rt.miss | tsel[36];
            s7_reg.t    <= tsel[34:0];
            s7_reg.dsgn <= rt.dsgn;
            s7_reg.org  <= rt.org;
            s7_reg.dmag <= rt.dmag;
            s7_reg.nd   <= rt.nd;

            s8_reg <= s7_reg;
            for (int i = 0; i < 3; i++)
                s8_prod_reg[i] <= s7_reg.dmag[i] * s7_reg.t;

            s9_reg <= s8_reg;
            for (int i = 0; i < 3; i++)
            begin
                s9_dv_reg[i].den <= s8_reg.nd;
                s9_dv_reg[i].rem <= {{(DIV_DEN_W-(DIV_NUM_W-DIV_Q_W)){1'b0}},
                                     numo[i][DIV_NUM_W-1:DIV_Q_W]};
                s9_dv_reg[i].nq  <= numo[i][DIV_Q_W-1:0];
            end
        end
    end

    dv_t  dq2 [0:2][0:DIV_STAGES];
    pnt_t p4  [0:DIV_STAGES];
    logic v4c [0:DIV_STAGES];

    assign p4[0]  = s9_reg;
    assign v4c[0] = v9_reg;

    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        assign dq2[j][0] = s9_dv_reg[j];
        for (genvar k = 0; k < DIV_STAGES; k++)
        begin : g_cell
            rsi_div_cell u_cell (
                .clk      (clk),
                .en       (en),
                .cell_in  (dq2[j][k]),
                .cell_out (dq2[j][k+1])
            );
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_dv2
        logic vk_reg;
        pnt_t pk_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vk_reg <= 1'b0;
            else if (en)
                vk_reg <= v4c[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                pk_reg <= p4[k];
        end

        assign v4c[k+1] = vk_reg;
        assign p4[k+1]  = pk_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v1c[SQ_STAGES];
            v5_reg <= v2c[DIV_STAGES];
            v6_reg <= v5_reg;
            v7_reg <= v3c[SQ_STAGES];
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    // hit point, saturation, output register
    pnt_t                   pf;
    logic [2:0][37:0]       pw;
    logic [2:0][WORD_W-1:0] psat;
    logic [RAD_W-1:0]       dsat;

    always_comb
    begin
        pf = p4[DIV_STAGES];
        for (int i = 0; i < 3; i++)
        begin
            pw[i] = pf.dsgn[i]
                  ? {{6{pf.org[i][WORD_W-1]}}, pf.org[i]} - {2'b00, dq2[i][DIV_STAGES].nq}
                  : {{6{pf.org[i][WORD_W-1]}}, pf.org[i]} + {2'b00, dq2[i][DIV_STAGES].nq};
            if (!pw[i][37] && (pw[i][37:31] != 7'd0))
                psat[i] = 32'h7FFF_FFFF;
            else if (pw[i][37] && (pw[i][37:31] != 7'h7F))
                psat[i] = 32'h8000_0000;
            else
                psat[i] = pw[i][31:0];
        end
        dsat = (pf.t[34:31] != 4'd0) ? {RAD_W{1'b1}} : pf.t[30:0];
    end

    logic                   out_vld_reg;
    logic                   out_hit_reg;
    logic [RAD_W-1:0]       out_dist_reg;
    logic [2:0][WORD_W-1:0] out_pnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= v4c[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hit_reg  <= !pf.miss;
            out_dist_reg <= pf.miss ? '0 : dsat;
            for (int i = 0; i < 3; i++)
                out_pnt_reg[i] <= pf.miss ? '0 : psat[i];
        end
    end

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-RAD_W-3*WORD_W){1'b0}},
                            out_pnt_reg[2], out_pnt_reg[1], out_pnt_reg[0], out_dist_reg};

endmodule
